>>> design/cfm_pkg.sv
package cfm_pkg;

	localparam int RefWidth          = 25;
	localparam int HoldWidth         = 4;
	localparam int CfgIndexWidth     = 1;
	localparam int CharWidth         = 6;
	localparam int DecDigits         = 8;
	localparam int ShownDigits       = 5;
	localparam int BandCount         = 11;
	localparam int BandIdxWidth      = 4;
	localparam int LimitWidth        = 15;
	localparam int PeriodWidthDef    = 16;
	localparam int FactorFractionDef = 20;
	localparam int DigitCountDef     = 5;
	localparam longint DecScale      = 64'd10000000;

	localparam logic [CfgIndexWidth-1:0] RegReferenceClock = 1'b0;
	localparam logic [CfgIndexWidth-1:0] RegHoldBand       = 1'b1;

	localparam logic [RefWidth-1:0]  RefClockReset = 25'd1048576;
	localparam logic [HoldWidth-1:0] HoldBandReset = 4'd2;

	localparam logic [CharWidth-1:0] CharSpace = 6'd32;
	localparam logic [CharWidth-1:0] CharZero  = 6'd48;
	localparam logic [CharWidth-1:0] CharNine  = 6'd57;

	localparam logic [BandIdxWidth-1:0] BandClosed = 4'd9;
	localparam logic [BandIdxWidth-1:0] BandOpen   = 4'd10;

	typedef logic [DecDigits-1:0][3:0] bcd_t;

	function automatic logic [LimitWidth-1:0] band_limit(input logic [BandIdxWidth-1:0] idx);
		case (idx)
			4'd0:    return 15'd116;
			4'd1:    return 15'd600;
			4'd2:    return 15'd1000;
			4'd3:    return 15'd3000;
			4'd4:    return 15'd5000;
			4'd5:    return 15'd8000;
			4'd6:    return 15'd10000;
			4'd7:    return 15'd12001;
			4'd8:    return 15'd15000;
			4'd9:    return 15'd20000;
			default: return '0;
		endcase
	endfunction

	// Calibration factor in unsigned Q1.fb, rounded to nearest.
	function automatic longint band_factor(input int fb, input int idx);
		longint k;
		case (idx)
			0:       k = 64'd11110000;
			1:       k = 64'd11188000;
			2:       k = 64'd11160000;
			3:       k = 64'd11170000;
			4:       k = 64'd11160000;
			5:       k = 64'd11158600;
			6:       k = 64'd11193170;
			7:       k = 64'd11100830;
			8:       k = 64'd11158223;
			9:       k = 64'd11084170;
			default: k = DecScale;
		endcase
		return (k * (longint'(1) << fb) + DecScale / 2) / DecScale;
	endfunction

endpackage

>>> design/cfm_band.sv
module cfm_band #(
	parameter int PW = cfm_pkg::PeriodWidthDef,
	parameter int FB = cfm_pkg::FactorFractionDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [cfm_pkg::RefWidth-1:0] ref_clock,
	input  logic [PW-1:0]                period,
	output logic [FB:0]                  factor,
	output logic                         done
);
	import cfm_pkg::*;

	localparam int FW    = FB + 1;
	localparam int ProdW = LimitWidth + PW;
	localparam int CmpW  = (ProdW > RefWidth) ? ProdW : RefWidth;

	logic [FW-1:0]           factor_tab [BandCount];
	logic                    busy_q;
	logic                    done_q;
	logic [BandIdxWidth-1:0] band_q;
	logic [FW-1:0]           factor_q;
	logic [ProdW-1:0]        bound;
	logic [CmpW-1:0]         ref_ext;
	logic [CmpW-1:0]         bound_ext;
	logic                    hit;

	for (genvar g = 0; g < BandCount; g++) begin : g_factor
		assign factor_tab[g] = FW'(band_factor(FB, g));
	end

	assign bound     = ProdW'(band_limit(band_q)) * ProdW'(period);
	assign ref_ext   = CmpW'(ref_clock);
	assign bound_ext = CmpW'(bound);

	always_comb begin
		case (band_q)
			BandOpen:   hit = 1'b1;
			BandClosed: hit = (ref_ext <= bound_ext);
			default:    hit = (ref_ext < bound_ext);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			band_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				band_q <= '0;
			end else if (busy_q) begin
				if (hit) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					band_q <= band_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && hit) begin
			factor_q <= factor_tab[band_q];
		end
	end

	assign factor = factor_q;
	assign done   = done_q;

endmodule

>>> design/cfm_mul.sv
module cfm_mul #(
	parameter int FB = cfm_pkg::FactorFractionDef
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [cfm_pkg::RefWidth-1:0]    mcand,
	input  logic [FB:0]                     mplier,
	output logic [cfm_pkg::RefWidth+FB:0]   product,
	output logic                            done
);
	import cfm_pkg::*;

	localparam int FW   = FB + 1;
	localparam int CntW = $clog2(FW);

	logic [RefWidth-1:0] acc_q;
	logic [FW-1:0]       lo_q;
	logic [RefWidth:0]   sum;
	logic [CntW-1:0]     cnt_q;
	logic                busy_q;
	logic                done_q;

	assign sum = {1'b0, acc_q} + (lo_q[0] ? {1'b0, mcand} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(FW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			lo_q  <= mplier;
		end else if (busy_q) begin
			acc_q <= sum[RefWidth:1];
			lo_q  <= {sum[0], lo_q[FW-1:1]};
		end
	end

	assign product = {acc_q, lo_q};
	assign done    = done_q;

endmodule

>>> design/cfm_div.sv
module cfm_div #(
	parameter int PW = cfm_pkg::PeriodWidthDef,
	parameter int FB = cfm_pkg::FactorFractionDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cfm_pkg::RefWidth+FB:0] product,
	input  logic [PW-1:0]                 period,
	output logic [cfm_pkg::RefWidth-1:0]  quotient,
	output cfm_pkg::bcd_t                 bcd,
	output logic                          done
);
	import cfm_pkg::*;

	localparam int FW   = FB + 1;
	localparam int PrW  = RefWidth + FW;
	localparam int RndW = PW + FB - 1;
	localparam int SumW = ((PrW > RndW) ? PrW : RndW) + 1;
	localparam int NW   = SumW - FB;
	localparam int QW   = RefWidth;
	localparam int CntW = $clog2(QW);

	logic [SumW-1:0]        sum_full;
	logic [NW-1:0]          num_full;
	logic [PW-1:0]          rem_q;
	logic [QW-1:0]          num_q;
	logic [QW-1:0]          quo_q;
	bcd_t                   bcd_q;
	bcd_t                   bcd_next;
	logic [DecDigits-1:0][3:0] adj;
	logic [DecDigits*4:0]   shifted;
	logic [PW:0]            trial;
	logic [PW:0]            diff;
	logic                   ge;
	logic [CntW-1:0]        cnt_q;
	logic                   busy_q;
	logic                   done_q;

	// Round half up by adding half the divisor before dropping the fraction.
	assign sum_full = SumW'(product) + (SumW'(period) << (FB - 1));
	assign num_full = sum_full[SumW-1:FB];

	assign trial = {rem_q, num_q[QW-1]};
	assign diff  = trial - {1'b0, period};
	assign ge    = (trial >= {1'b0, period});

	always_comb begin
		for (int d = 0; d < DecDigits; d++) begin
			adj[d] = (bcd_q[d] >= 4'd5) ? bcd_q[d] + 4'd3 : bcd_q[d];
		end
		shifted  = {adj, ge};
		bcd_next = shifted[DecDigits*4-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= PW'(num_full >> QW);
			num_q <= num_full[QW-1:0];
			quo_q <= '0;
			bcd_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[PW-1:0] : trial[PW-1:0];
			num_q <= {num_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
			bcd_q <= bcd_next;
		end
	end

	assign quotient = quo_q;
	assign bcd      = bcd_q;
	assign done     = done_q;

endmodule

>>> design/capture_frequency_meter.sv
// Channel  Handshake                Payload
// in       in_valid / in_ready      capture_first, capture_second
// out      out_valid / out_ready    frequency, digit_ten_thousands .. digit_units, period_zero
// cfg      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A capture pair passes from acceptance through the band search, the serial multiplier
// and the bit-serial divider with its BCD shifter to a result. A pair whose period is
// zero skips those steps and goes straight to the load state; a pair of zeros
// is taken and dropped. One pair is in work at a time; in_ready is high between pairs,
// also while a result waits in the output register. cfg_ready is always high.
// Reset clears the held period and loads the register defaults.
module capture_frequency_meter #(
	parameter int PERIOD_WIDTH         = cfm_pkg::PeriodWidthDef,
	parameter int FACTOR_FRACTION_BITS = cfm_pkg::FactorFractionDef,
	parameter int DIGIT_COUNT          = cfm_pkg::DigitCountDef
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [PERIOD_WIDTH-1:0]           capture_first,
	input  logic [PERIOD_WIDTH-1:0]           capture_second,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [cfm_pkg::RefWidth-1:0]      frequency,
	output logic [cfm_pkg::CharWidth-1:0]     digit_ten_thousands,
	output logic [cfm_pkg::CharWidth-1:0]     digit_thousands,
	output logic [cfm_pkg::CharWidth-1:0]     digit_hundreds,
	output logic [cfm_pkg::CharWidth-1:0]     digit_tens,
	output logic [cfm_pkg::CharWidth-1:0]     digit_units,
	output logic                              period_zero,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cfm_pkg::CfgIndexWidth-1:0] cfg_index,
	input  logic [cfm_pkg::RefWidth-1:0]      cfg_data
);
	import cfm_pkg::*;

	localparam int PW = PERIOD_WIDTH;
	localparam int FB = FACTOR_FRACTION_BITS;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_BAND = 5'b00010,
		S_MUL  = 5'b00100,
		S_DIV  = 5'b01000,
		S_LOAD = 5'b10000
	} state_t;

	state_t                 state_q;
	logic                   launch_q;
	logic [RefWidth-1:0]    ref_clock_q;
	logic [HoldWidth-1:0]   hold_band_q;
	logic [PW-1:0]          held_q;
	logic [PW-1:0]          per_q;
	logic                   zero_q;
	logic                   out_valid_q;
	logic [RefWidth-1:0]    frequency_q;
	logic [ShownDigits-1:0][CharWidth-1:0] chars_q;
	logic [ShownDigits-1:0][CharWidth-1:0] chars;
	logic                   period_zero_q;

	logic                   in_fire;
	logic                   both_zero;
	logic [PW-1:0]          per_raw;
	logic [PW-1:0]          per_diff;
	logic                   snap;
	logic [PW-1:0]          per_eff;
	logic                   load_fire;

	logic                   band_done;
	logic [FB:0]            factor;
	logic                   mul_done;
	logic [RefWidth+FB:0]   product;
	logic                   div_done;
	logic [RefWidth-1:0]    quotient;
	bcd_t                   bcd;
	bcd_t                   bcd_sel;
	logic [DecDigits-1:0]   lead;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign both_zero = (capture_first == '0) && (capture_second == '0);

	assign per_raw  = capture_second - capture_first;
	assign per_diff = (per_raw >= held_q) ? per_raw - held_q : held_q - per_raw;
	assign snap     = (per_diff <= PW'(hold_band_q));
	assign per_eff  = snap ? held_q : per_raw;

	assign load_fire = (state_q == S_LOAD) && (!out_valid_q || out_ready);

	cfm_band #(.PW(PW), .FB(FB)) u_band (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (launch_q && (state_q == S_BAND)),
		.ref_clock (ref_clock_q),
		.period    (per_q),
		.factor    (factor),
		.done      (band_done)
	);

	cfm_mul #(.FB(FB)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (launch_q && (state_q == S_MUL)),
		.mcand   (ref_clock_q),
		.mplier  (factor),
		.product (product),
		.done    (mul_done)
	);

	cfm_div #(.PW(PW), .FB(FB)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (launch_q && (state_q == S_DIV)),
		.product  (product),
		.period   (per_q),
		.quotient (quotient),
		.bcd      (bcd),
		.done     (div_done)
	);

	always_comb begin
		logic upper;
		upper   = 1'b0;
		bcd_sel = zero_q ? '0 : bcd;
		for (int j = DecDigits - 1; j >= 0; j--) begin
			upper   = upper | (bcd_sel[j] != 4'd0);
			lead[j] = upper;
		end
		for (int i = 0; i < ShownDigits; i++) begin
			chars[i] = ((i < DIGIT_COUNT) && lead[i]) ? CharZero + {2'b00, bcd_sel[i]}
				: CharSpace;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			launch_q    <= 1'b0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
			ref_clock_q <= RefClockReset;
			hold_band_q <= HoldBandReset;
		end else begin
			launch_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_fire && !both_zero) begin
						if (!snap) begin
							held_q <= per_raw;
						end
						if (per_eff == '0) begin
							state_q <= S_LOAD;
						end else begin
							state_q  <= S_BAND;
							launch_q <= 1'b1;
						end
					end
				end
				S_BAND: begin
					if (band_done) begin
						state_q  <= S_MUL;
						launch_q <= 1'b1;
					end
				end
				S_MUL: begin
					if (mul_done) begin
						state_q  <= S_DIV;
						launch_q <= 1'b1;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (load_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (load_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_valid) begin
				case (cfg_index)
					RegReferenceClock: ref_clock_q <= cfg_data;
					RegHoldBand:       hold_band_q <= cfg_data[HoldWidth-1:0];
					default:           ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && !both_zero) begin
			per_q  <= per_eff;
			zero_q <= (per_eff == '0);
		end
		if (load_fire) begin
			frequency_q   <= zero_q ? '0 : quotient;
			chars_q       <= chars;
			period_zero_q <= zero_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign frequency           = frequency_q;
	assign digit_units         = chars_q[0];
	assign digit_tens          = chars_q[1];
	assign digit_hundreds      = chars_q[2];
	assign digit_thousands     = chars_q[3];
	assign digit_ten_thousands = chars_q[4];
	assign period_zero         = period_zero_q;

endmodule

>>> design/cfm_checker.sv
module cfm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [cfm_pkg::RefWidth-1:0]  frequency,
	input logic [cfm_pkg::CharWidth-1:0] digit_ten_thousands,
	input logic [cfm_pkg::CharWidth-1:0] digit_thousands,
	input logic [cfm_pkg::CharWidth-1:0] digit_hundreds,
	input logic [cfm_pkg::CharWidth-1:0] digit_tens,
	input logic [cfm_pkg::CharWidth-1:0] digit_units,
	input logic                          period_zero
);
	import cfm_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frequency))
		else $error("result transaction dropped or changed while stalled");

	a_zero_period: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && period_zero |-> frequency == '0 && digit_units == CharSpace)
		else $error("zero period with nonzero frequency");

	a_zero_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frequency == '0 |-> digit_ten_thousands == CharSpace &&
		digit_thousands == CharSpace && digit_hundreds == CharSpace &&
		digit_tens == CharSpace && digit_units == CharSpace)
		else $error("zero frequency shows digits");

	a_units_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frequency != '0 |-> digit_units >= CharZero && digit_units <= CharNine)
		else $error("units digit not a decimal character");

	a_lead_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && digit_ten_thousands != CharSpace |-> digit_thousands != CharSpace &&
		digit_hundreds != CharSpace && digit_tens != CharSpace)
		else $error("blank inside the digit field");

endmodule

bind capture_frequency_meter cfm_checker u_cfm_checker (.*);

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;

	import cfm_pkg::*;

	localparam int PW = PeriodWidthDef;
	localparam int FB = FactorFractionDef;
	localparam int SETTLE_CYCLES = 100;
	localparam int QUIET_LIMIT = 3000;
	localparam int PHASE_ITEMS = 125;
	localparam int PHASES = 6;

	localparam int unsigned BAND_EDGE [10] = '{
		116, 600, 1000, 3000, 5000, 8000, 10000, 12001, 15000, 20000
	};
	localparam longint unsigned CAL_E7 [11] = '{
		11110000, 11188000, 11160000, 11170000, 11160000, 11158600,
		11193170, 11100830, 11158223, 11084170, 10000000
	};

	typedef struct packed {
		logic [RefWidth-1:0]             frequency;
		logic [4:0][CharWidth-1:0]       digits;
		logic                            period_zero;
	} reading_t;

	typedef enum {ROW_REG, ROW_PAIR} row_kind_t;

	typedef struct {
		row_kind_t                 kind;
		logic [CfgIndexWidth-1:0]  index;
		logic [RefWidth-1:0]       data;
		logic [PW-1:0]             first;
		logic [PW-1:0]             second;
		bit                        typed;
		reading_t                  want;
	} row_t;

	localparam reading_t BLANK_ZERO_PERIOD = {25'd0, {5{CharSpace}}, 1'b1};
	localparam reading_t BLANK_NO_CLOCK    = {25'd0, {5{CharSpace}}, 1'b0};
	localparam reading_t FULL_RATE_DEFAULT = {25'd1048576, CharZero + 6'd4, CharZero + 6'd8,
		CharZero + 6'd5, CharZero + 6'd7, CharZero + 6'd6, 1'b0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [PW-1:0] capture_first = '0;
	logic [PW-1:0] capture_second = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [RefWidth-1:0] frequency;
	logic [CharWidth-1:0] digit_ten_thousands;
	logic [CharWidth-1:0] digit_thousands;
	logic [CharWidth-1:0] digit_hundreds;
	logic [CharWidth-1:0] digit_tens;
	logic [CharWidth-1:0] digit_units;
	logic period_zero;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIndexWidth-1:0] cfg_index = '0;
	logic [RefWidth-1:0] cfg_data = '0;

	logic cur_typed = 1'b0;
	reading_t cur_want = '0;

	logic [RefWidth-1:0] ref_clock = RefClockReset;
	logic [HoldWidth-1:0] hold_band = HoldBandReset;
	logic [PW-1:0] held_period = '0;

	reading_t pending_readings [$];
	row_t rows [$];
	int unsigned errors = 0;
	int unsigned quiet_cycles = 0;
	bit no_stall = 1'b0;

	string digit_name [5] = '{"digit_units", "digit_tens", "digit_hundreds",
		"digit_thousands", "digit_ten_thousands"};

	capture_frequency_meter uut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.capture_first       (capture_first),
		.capture_second      (capture_second),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.frequency           (frequency),
		.digit_ten_thousands (digit_ten_thousands),
		.digit_thousands     (digit_thousands),
		.digit_hundreds      (digit_hundreds),
		.digit_tens          (digit_tens),
		.digit_units         (digit_units),
		.period_zero         (period_zero),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_stall)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	function automatic bit predict_reading(input logic [PW-1:0] first, input logic [PW-1:0] second,
			output reading_t r);
		logic [PW-1:0] per;
		logic [PW-1:0] diff;
		longint unsigned factor, num, den, freq, rem;
		int band;
		r = '0;
		if (first == '0 && second == '0)
			return 1'b0;
		per = second - first;
		diff = (per >= held_period) ? per - held_period : held_period - per;
		if (diff <= hold_band)
			per = held_period;
		else
			held_period = per;
		freq = 0;
		if (per != '0) begin
			band = 10;
			if (longint'(ref_clock) <= longint'(BAND_EDGE[9]) * per)
				band = 9;
			for (int i = 8; i >= 0; i--)
				if (longint'(ref_clock) < longint'(BAND_EDGE[i]) * per)
					band = i;
			factor = (CAL_E7[band] * (longint'(1) << FB) + 64'd5000000) / 64'd10000000;
			den = longint'(per) << FB;
			num = longint'(ref_clock) * factor + (den >> 1);
			freq = num / den;
		end
		r.frequency = freq[RefWidth-1:0];
		rem = freq;
		for (int i = 0; i < 5; i++) begin
			r.digits[i] = (rem != 0) ? CharZero + CharWidth'(rem % 10) : CharSpace;
			rem = rem / 10;
		end
		r.period_zero = (per == '0);
		return 1'b1;
	endfunction

	always @(posedge clk) begin : monitor
		reading_t got;
		reading_t want;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				moved = 1'b1;
				got = {frequency, digit_ten_thousands, digit_thousands, digit_hundreds,
					digit_tens, digit_units, period_zero};
				if (pending_readings.size() == 0) begin
					$error("result transaction with no capture pending");
					errors++;
				end else begin
					want = pending_readings.pop_front();
					if (got.frequency !== want.frequency) begin
						$error("frequency: expected %0d, got %0d", want.frequency, got.frequency);
						errors++;
					end
					for (int i = 0; i < 5; i++)
						if (got.digits[i] !== want.digits[i]) begin
							$error("%s: expected %0d, got %0d", digit_name[i], want.digits[i],
								got.digits[i]);
							errors++;
						end
					if (got.period_zero !== want.period_zero) begin
						$error("period_zero: expected %0d, got %0d", want.period_zero,
							got.period_zero);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				if (cfg_index == RegReferenceClock)
					ref_clock = cfg_data;
				else if (cfg_index == RegHoldBand)
					hold_band = cfg_data[HoldWidth-1:0];
			end
			if (in_valid && in_ready) begin
				moved = 1'b1;
				if (predict_reading(capture_first, capture_second, want)) begin
					if (cur_typed)
						want = cur_want;
					pending_readings.push_back(want);
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
		end
	end

	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : sink
		int unsigned gap;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = pick_gap();
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	task automatic drain();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending_readings.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [CfgIndexWidth-1:0] idx,
			input logic [RefWidth-1:0] data);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_capture(input logic [PW-1:0] first, input logic [PW-1:0] second,
			input bit typed, input reading_t want);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		capture_first <= first;
		capture_second <= second;
		cur_typed <= typed;
		cur_want <= want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned counted, pick, off;
		logic [PW-1:0] first, per;
		logic [RefWidth-1:0] clock_pick;

		rows.push_back('{ROW_PAIR, RegReferenceClock, '0, 16'd0, 16'd0, 1'b0, '0});
		rows.push_back('{ROW_PAIR, RegReferenceClock, '0, 16'd5, 16'd5, 1'b1, BLANK_ZERO_PERIOD});
		rows.push_back('{ROW_PAIR, RegReferenceClock, '0, 16'd0, 16'd1000, 1'b0, '0});
		rows.push_back('{ROW_PAIR, RegReferenceClock, '0, 16'd1000, 16'd0, 1'b0, '0});
		rows.push_back('{ROW_PAIR, RegReferenceClock, '0, 16'hFFFF, 16'd0, 1'b1, FULL_RATE_DEFAULT});
		rows.push_back('{ROW_PAIR, RegReferenceClock, '0, 16'd0, 16'hFFFF, 1'b0, '0});
		rows.push_back('{ROW_PAIR, RegReferenceClock, '0, 16'd1, 16'hFFFF, 1'b0, '0});
		rows.push_back('{ROW_PAIR, RegReferenceClock, '0, 16'd100, 16'd100, 1'b1,
			BLANK_ZERO_PERIOD});
		rows.push_back('{ROW_PAIR, RegReferenceClock, '0, 16'd0, 16'd3, 1'b0, '0});
		rows.push_back('{ROW_REG, RegHoldBand, 25'h1FFFFF3, '0, '0, 1'b0, '0});
		rows.push_back('{ROW_PAIR, RegReferenceClock, '0, 16'd9, 16'd9, 1'b0, '0});
		rows.push_back('{ROW_REG, RegHoldBand, 25'd0, '0, '0, 1'b0, '0});
		rows.push_back('{ROW_PAIR, RegReferenceClock, '0, 16'd0, 16'd9040, 1'b0, '0});
		rows.push_back('{ROW_PAIR, RegReferenceClock, '0, 16'd0, 16'd9039, 1'b0, '0});
		rows.push_back('{ROW_REG, RegReferenceClock, 25'd140000, '0, '0, 1'b0, '0});
		rows.push_back('{ROW_PAIR, RegReferenceClock, '0, 16'd10, 16'd17, 1'b0, '0});
		rows.push_back('{ROW_REG, RegReferenceClock, 25'd140001, '0, '0, 1'b0, '0});
		rows.push_back('{ROW_PAIR, RegReferenceClock, '0, 16'd10, 16'd17, 1'b0, '0});
		rows.push_back('{ROW_REG, RegReferenceClock, 25'd36003, '0, '0, 1'b0, '0});
		rows.push_back('{ROW_PAIR, RegReferenceClock, '0, 16'd0, 16'd3, 1'b0, '0});
		rows.push_back('{ROW_REG, RegReferenceClock, 25'd0, '0, '0, 1'b0, '0});
		rows.push_back('{ROW_PAIR, RegReferenceClock, '0, 16'd0, 16'd1, 1'b1, BLANK_NO_CLOCK});
		rows.push_back('{ROW_REG, RegReferenceClock, 25'h1FFFFFF, '0, '0, 1'b0, '0});
		rows.push_back('{ROW_PAIR, RegReferenceClock, '0, 16'd0, 16'd1, 1'b0, '0});
		rows.push_back('{ROW_REG, RegHoldBand, 25'd15, '0, '0, 1'b0, '0});
		rows.push_back('{ROW_REG, RegReferenceClock, 25'd1, '0, '0, 1'b0, '0});
		rows.push_back('{ROW_PAIR, RegReferenceClock, '0, 16'd0, 16'hFFFF, 1'b0, '0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			if (rows[i].kind == ROW_REG)
				write_register(rows[i].index, rows[i].data);
			else
				send_capture(rows[i].first, rows[i].second, rows[i].typed, rows[i].want);

		for (int phase = 0; phase < PHASES; phase++) begin
			no_stall = (phase == 2);
			case ($urandom_range(0, 5))
				0: clock_pick = RefClockReset;
				1: clock_pick = RefWidth'($urandom);
				2: clock_pick = RefWidth'($urandom_range(1, 1000));
				3: clock_pick = (phase == 4) ? 25'd0 : 25'h1FFFFFF;
				default: clock_pick = RefWidth'($urandom_range(1, 16777216));
			endcase
			write_register(RegReferenceClock, clock_pick);
			write_register(RegHoldBand, RefWidth'($urandom));
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				first = PW'($urandom);
				if (pick < 4) begin
					send_capture('0, '0, 1'b0, '0);
				end else begin
					if (pick < 10) begin
						per = '0;
						if (first == '0)
							first = PW'(1);
					end else if (pick < 30) begin
						off = $urandom_range(0, hold_band + 2);
						per = $urandom_range(0, 1) ? PW'(held_period + off)
							: PW'(held_period - off);
					end else begin
						per = PW'($urandom & ((32'd1 << $urandom_range(0, PW)) - 1));
					end
					send_capture(first, first + per, 1'b0, '0);
					counted++;
					if ($urandom_range(0, 99) == 0)
						drain();
				end
			end
		end
		write_register(RegReferenceClock, RefClockReset);
		write_register(RegHoldBand, HoldBandReset);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> filelist.f
design/cfm_pkg.sv
design/cfm_band.sv
design/cfm_mul.sv
design/cfm_div.sv
design/capture_frequency_meter.sv
design/cfm_checker.sv
test/tb.sv
